// ===== rtl/pilot_channel_interp_equalizer_unit_macros.svh =====
// assertion macros used by the equalizer checker
`ifndef PILOT_CHANNEL_INTERP_EQUALIZER_UNIT_MACROS_SVH
`define PILOT_CHANNEL_INTERP_EQUALIZER_UNIT_MACROS_SVH

// same-cycle implication
`define PCEQ_ASSERT_SAME(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("pceq same-cycle check failed");

// next-cycle implication
`define PCEQ_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("pceq next-cycle check failed");

`endif

// ===== rtl/pceq_pkg.sv =====
// types, codes and constant tables of the pilot channel equalizer
`timescale 1ns / 1ps
package pceq_pkg;

    localparam int FREQ_TAPS_MAX = 16;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_PILOT = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;

    localparam logic [1:0] REG_TIME_TAPS = 2'd0;
    localparam logic [1:0] REG_FREQ_TAPS = 2'd1;
    localparam logic [1:0] REG_CARRIERS  = 2'd2;
    localparam logic [1:0] REG_SYMBOLS   = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [10:0]        carrier;
        logic [3:0]         symbol;
        logic signed [15:0] known_re;
        logic signed [15:0] known_im;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] eq_re;
        logic signed [15:0] eq_im;
        logic               clipped;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_PMUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_WIN_RD,
        ST_WIN_MUL,
        ST_WIN_WR,
        ST_DMUL,
        ST_DOUT
    } t_state;

    // round(16384 * n / c), indexed by {c-1, n-1}
    localparam logic [14:0] WEIGHT_LUT [64] = '{
        15'd16384, 15'd0,     15'd0,     15'd0,     15'd0,     15'd0,     15'd0,     15'd0,
        15'd8192,  15'd16384, 15'd0,     15'd0,     15'd0,     15'd0,     15'd0,     15'd0,
        15'd5461,  15'd10923, 15'd16384, 15'd0,     15'd0,     15'd0,     15'd0,     15'd0,
        15'd4096,  15'd8192,  15'd12288, 15'd16384, 15'd0,     15'd0,     15'd0,     15'd0,
        15'd3277,  15'd6554,  15'd9830,  15'd13107, 15'd16384, 15'd0,     15'd0,     15'd0,
        15'd2731,  15'd5461,  15'd8192,  15'd10923, 15'd13653, 15'd16384, 15'd0,     15'd0,
        15'd2341,  15'd4681,  15'd7022,  15'd9362,  15'd11703, 15'd14043, 15'd16384, 15'd0,
        15'd2048,  15'd4096,  15'd6144,  15'd8192,  15'd10240, 15'd12288, 15'd14336, 15'd16384
    };

    // triangular frequency weight, Q1.14
    function automatic logic [14:0] freq_weight(input logic [4:0] f, input logic [4:0] j);
        logic [4:0] half;
        logic [4:0] c;
        logic [4:0] n;
        logic [4:0] cm;
        logic [4:0] nm;
        half = f >> 1;
        c    = (f + 5'd1) >> 1;
        n    = (j < half) ? (j + 5'd1) : (f - j);
        cm   = c - 5'd1;
        nm   = n - 5'd1;
        if (j == half) begin
            return 15'd16384;
        end
        return WEIGHT_LUT[{cm[2:0], nm[2:0]}];
    endfunction

    function automatic logic signed [23:0] ext_a(input logic signed [15:0] v);
        return {{8{v[15]}}, v};
    endfunction

    function automatic logic signed [16:0] ext_b(input logic signed [15:0] v);
        return {v[15], v};
    endfunction

    function automatic logic signed [23:0] sat_grid(input logic signed [25:0] v);
        if (v > 26'sd8388607) begin
            return 24'sh7FFFFF;
        end
        if (v < -26'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

endpackage

// ===== rtl/pilot_channel_interp_equalizer_unit.sv =====
// pilot-based channel grid with 2-d interpolation and zero-forcing equalizer
`timescale 1ns / 1ps
// pilot: products, division, then read-modify-write of the T*F window (T, F the window);
//   start of subframe moves the T spill-over rows to the top, then clears the rows below them
// throughput: one item at a time, set by the shared multiplier and the one-bit-a-cycle divider
//   and by the one grid memory used for the window read-modify-write
// reset: a clearing pass zeroes every row and column of the grid,
//   input stalled meanwhile; configuration writes are taken at any time
module pilot_channel_interp_equalizer_unit
    import pceq_pkg::*;
#(
    parameter int FFT_MAX       = 2048,
    parameter int TIME_TAPS_MAX = 8,
    parameter int SYMBOLS_MAX   = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int ROWS  = SYMBOLS_MAX + TIME_TAPS_MAX;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(FFT_MAX);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    // configuration registers
    logic [3:0]  r_time_taps;
    logic [4:0]  r_freq_taps;
    logic [11:0] r_carriers;
    logic [3:0]  r_symbols;

    // sequencer and item
    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [4:0]  r_ti;
    logic [4:0]  r_fj;
    logic [2:0]  r_step;

    // pilot arithmetic
    logic [31:0]        r_den;
    logic signed [32:0] r_nr;
    logic signed [32:0] r_ni;
    logic signed [15:0] r_hr;
    logic signed [15:0] r_hi;
    logic               r_part;
    logic               r_neg;
    logic [45:0]        r_rem;
    logic [46:0]        r_sd;
    logic [14:0]        r_q;
    logic [3:0]         r_cnt;
    logic signed [18:0] r_inc_re;

    // shared multiplier
    logic signed [23:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [40:0] r_prod;

    // data path
    logic signed [41:0] r_acc_re;
    logic signed [41:0] r_acc_im;
    logic               r_out_valid;
    t_out_item          r_out;

    // grid memory
    logic [47:0]   mem [DEPTH];
    logic [47:0]   r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [47:0]   mem_wdata;

    // clamped configuration
    logic [4:0]  tt_ext, ss_ext, t_eff, s_eff, f_eff;
    logic [12:0] cc_ext, c_eff;

    assign tt_ext = {1'b0, r_time_taps};
    assign ss_ext = {1'b0, r_symbols};
    assign cc_ext = {1'b0, r_carriers};
    assign t_eff  = (tt_ext == 5'd0) ? 5'd1 :
                    ((tt_ext > 5'(TIME_TAPS_MAX)) ? 5'(TIME_TAPS_MAX) : tt_ext);
    assign s_eff  = (ss_ext == 5'd0) ? 5'd1 :
                    ((ss_ext > 5'(SYMBOLS_MAX)) ? 5'(SYMBOLS_MAX) : ss_ext);
    assign f_eff  = (r_freq_taps == 5'd0) ? 5'd1 :
                    ((r_freq_taps > 5'(FREQ_TAPS_MAX)) ? 5'(FREQ_TAPS_MAX) : r_freq_taps);
    assign c_eff  = (cc_ext == 13'd0) ? 13'd1 :
                    ((cc_ext > 13'(FFT_MAX)) ? 13'(FFT_MAX) : cc_ext);

    // input handshake
    logic in_accept;
    logic in_car_ok, in_sym_ok;
    assign in_accept = i_in_valid && !o_in_stall;
    assign in_car_ok = 13'(i_in_data.carrier) < c_eff;
    assign in_sym_ok = 5'(i_in_data.symbol) < s_eff;

    // output slot free for a new transaction
    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // sweep bounds for the clear and move passes
    logic col_last, clr_last_row, move_last_row;
    assign col_last      = (r_col == CW'(FFT_MAX - 1));
    assign clr_last_row  = (r_row == RW'(ROWS - 1));
    assign move_last_row = ((6'(r_row) + 6'd1) == 6'(t_eff));

    // window position of the current tap
    logic signed [13:0] col_s;
    logic               win_in;
    logic [RW-1:0]      win_row;
    logic [CW-1:0]      win_col;
    logic [14:0]        weight;
    logic               last_j, last_i;

    assign col_s   = 14'(r_item.carrier) + 14'(r_fj) - 14'(f_eff >> 1);
    assign win_in  = !col_s[13] && (col_s[12:0] < c_eff);
    assign win_row = RW'(6'(r_item.symbol) + 6'(r_ti));
    assign win_col = CW'(col_s[12:0]);
    assign weight  = freq_weight(f_eff, r_fj);
    assign last_j  = ((r_fj + 5'd1) == f_eff);
    assign last_i  = ((r_ti + 5'd1) == t_eff);

    // window increment from the product register: floor((h*w + 2^11) / 2^12)
    logic signed [40:0] inc_rnd;
    logic signed [18:0] inc_now;
    logic signed [23:0] e_re, e_im;
    logic signed [23:0] new_re, new_im;

    assign inc_rnd = r_prod + 41'sd2048;
    assign inc_now = inc_rnd[30:12];
    assign e_re    = r_rdata[47:24];
    assign e_im    = r_rdata[23:0];
    assign new_re  = sat_grid(26'(e_re) + 26'(r_inc_re));
    assign new_im  = sat_grid(26'(e_im) + 26'(inc_now));

    // divider set-up for the selected part
    logic signed [32:0] n_sel;
    logic [32:0]        n_negv;
    logic [31:0]        mag;
    logic               neg_sel;
    logic [45:0]        dvd;
    logic [32:0]        dv2;
    logic               ovf;

    assign n_sel   = r_part ? r_ni : r_nr;
    assign neg_sel = n_sel[32];
    assign n_negv  = -n_sel;
    assign mag     = neg_sel ? n_negv[31:0] : n_sel[31:0];
    assign dvd     = 46'({mag, 13'b0}) + 46'(r_den);
    assign dv2     = {r_den, 1'b0};
    assign ovf     = {2'b00, dvd} >= {dv2, 15'b0};

    // restoring divider step
    logic        div_ge;
    logic [45:0] rem_next;
    logic [15:0] q16;
    logic signed [15:0] h_div, h_ovf;

    assign div_ge   = {1'b0, r_rem} >= r_sd;
    assign rem_next = div_ge ? (r_rem - r_sd[45:0]) : r_rem;
    assign q16      = {1'b0, r_q[13:0], div_ge};
    assign h_div    = r_neg ? -$signed(q16) : $signed(q16);
    assign h_ovf    = neg_sel ? 16'sh8000 : 16'sh7FFF;

    // output rounding and saturation
    logic signed [41:0] y_re_rnd, y_im_rnd;
    logic signed [25:0] y_re_s, y_im_s;
    logic signed [15:0] y_re, y_im;
    logic               clip_re, clip_im;

    assign y_re_rnd = r_acc_re + 42'sd32768;
    assign y_im_rnd = r_acc_im + 42'sd32768;
    assign y_re_s   = y_re_rnd[41:16];
    assign y_im_s   = y_im_rnd[41:16];

    always_comb begin
        clip_re = 1'b0;
        clip_im = 1'b0;
        y_re    = y_re_s[15:0];
        y_im    = y_im_s[15:0];
        if (y_re_s > 26'sd32767) begin
            y_re    = 16'sh7FFF;
            clip_re = 1'b1;
        end else if (y_re_s < -26'sd32768) begin
            y_re    = 16'sh8000;
            clip_re = 1'b1;
        end
        if (y_im_s > 26'sd32767) begin
            y_im    = 16'sh7FFF;
            clip_im = 1'b1;
        end else if (y_im_s < -26'sd32768) begin
            y_im    = 16'sh8000;
            clip_im = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (col_last && clr_last_row) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) begin
                    priority case (i_in_data.operation)
                        OP_START: n_state = ST_MOVE_RD;
                        OP_PILOT: n_state = (in_car_ok && in_sym_ok) ? ST_PMUL : ST_IDLE;
                        OP_DATA:  n_state = (in_car_ok && in_sym_ok) ? ST_DMUL : ST_DOUT;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MOVE_RD: n_state = ST_MOVE_WR;
            ST_MOVE_WR: begin
                // after the spill-over rows, clear everything below them
                n_state = (col_last && move_last_row) ? ST_CLEAR : ST_MOVE_RD;
            end
            ST_PMUL: begin
                if (r_step == 3'd6) n_state = (r_den == 32'd0) ? ST_IDLE : ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                if (ovf) n_state = r_part ? ST_WIN_RD : ST_DIV_INIT;
                else     n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == 4'd14) n_state = r_part ? ST_WIN_RD : ST_DIV_INIT;
            end
            ST_WIN_RD: begin
                if (win_in)                n_state = ST_WIN_MUL;
                else if (last_j && last_i) n_state = ST_IDLE;
            end
            ST_WIN_MUL: n_state = ST_WIN_WR;
            ST_WIN_WR:  n_state = (last_j && last_i) ? ST_IDLE : ST_WIN_RD;
            ST_DMUL: begin
                if (r_step == 3'd5) n_state = ST_DOUT;
            end
            ST_DOUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // memory port and multiplier operand selection
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = {r_row, r_col};
        mem_raddr  = {r_row, r_col};
        mem_wdata  = '0;
        mul_a      = '0;
        mul_b      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_MOVE_RD: begin
                mem_raddr = {RW'(6'(s_eff) + 6'(r_row)), r_col};
            end
            ST_MOVE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
            end
            ST_PMUL: begin
                unique case (r_step)
                    3'd0: begin
                        mul_a = ext_a(r_item.sample_re);
                        mul_b = ext_b(r_item.sample_re);
                    end
                    3'd1: begin
                        mul_a = ext_a(r_item.sample_im);
                        mul_b = ext_b(r_item.sample_im);
                    end
                    3'd2: begin
                        mul_a = ext_a(r_item.known_re);
                        mul_b = ext_b(r_item.sample_re);
                    end
                    3'd3: begin
                        mul_a = ext_a(r_item.known_im);
                        mul_b = ext_b(r_item.sample_im);
                    end
                    3'd4: begin
                        mul_a = ext_a(r_item.known_im);
                        mul_b = ext_b(r_item.sample_re);
                    end
                    3'd5: begin
                        mul_a = ext_a(r_item.known_re);
                        mul_b = ext_b(r_item.sample_im);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_DIV_INIT, ST_DIV: begin
                mem_we = 1'b0;
            end
            ST_WIN_RD: begin
                mem_raddr = {win_row, win_col};
                mul_a     = ext_a(r_hr);
                mul_b     = $signed({2'b00, weight});
            end
            ST_WIN_MUL: begin
                mem_raddr = {win_row, win_col};
                mul_a     = ext_a(r_hi);
                mul_b     = $signed({2'b00, weight});
            end
            ST_WIN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = {win_row, win_col};
                mem_wdata = {new_re, new_im};
            end
            ST_DMUL: begin
                mem_raddr = {RW'(r_item.symbol), CW'(r_item.carrier)};
                unique case (r_step)
                    3'd1: begin
                        mul_a = e_re;
                        mul_b = ext_b(r_item.sample_re);
                    end
                    3'd2: begin
                        mul_a = e_im;
                        mul_b = ext_b(r_item.sample_im);
                    end
                    3'd3: begin
                        mul_a = e_im;
                        mul_b = ext_b(r_item.sample_re);
                    end
                    3'd4: begin
                        mul_a = e_re;
                        mul_b = ext_b(r_item.sample_im);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_DOUT: begin
                o_in_stall = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // grid memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_taps <= 4'd4;
            r_freq_taps <= 5'd12;
            r_carriers  <= 12'd2048;
            r_symbols   <= 4'd14;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TIME_TAPS: r_time_taps <= i_cfg_data[3:0];
                REG_FREQ_TAPS: r_freq_taps <= i_cfg_data[4:0];
                REG_CARRIERS:  r_carriers  <= i_cfg_data;
                REG_SYMBOLS:   r_symbols   <= i_cfg_data[3:0];
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_col <= r_col + CW'(1);
                    if (col_last) begin
                        r_col <= '0;
                        r_row <= r_row + RW'(1);
                    end
                end
                ST_IDLE: begin
                    // start of subframe walks rows from the top
                    r_row <= '0;
                    r_col <= '0;
                end
                ST_MOVE_WR: begin
                    r_col <= r_col + CW'(1);
                    if (col_last) begin
                        r_col <= '0;
                        r_row <= move_last_row ? RW'(t_eff) : (r_row + RW'(1));
                    end
                end
                ST_DOUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_row <= r_row;
                end
            endcase
        end
    end

    // item and arithmetic registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_item   <= i_in_data;
                r_step   <= '0;
                r_acc_re <= '0;
                r_acc_im <= '0;
            end
            ST_PMUL: begin
                r_step <= r_step + 3'd1;
                r_part <= 1'b0;
                r_ti   <= '0;
                r_fj   <= '0;
                unique case (r_step)
                    3'd1: r_den <= r_prod[31:0];
                    3'd2: r_den <= r_den + r_prod[31:0];
                    3'd3: r_nr  <= r_prod[32:0];
                    3'd4: r_nr  <= r_nr + r_prod[32:0];
                    3'd5: r_ni  <= r_prod[32:0];
                    3'd6: r_ni  <= r_ni - r_prod[32:0];
                    default: r_den <= r_den;
                endcase
            end
            ST_DIV_INIT: begin
                r_neg <= neg_sel;
                r_rem <= dvd;
                r_sd  <= {dv2, 14'b0};
                r_q   <= '0;
                r_cnt <= '0;
                if (ovf) begin
                    // quotient beyond Q4.12 range
                    if (r_part) r_hi <= h_ovf;
                    else        r_hr <= h_ovf;
                    r_part <= !r_part;
                end
            end
            ST_DIV: begin
                r_rem <= rem_next;
                r_sd  <= r_sd >> 1;
                r_q   <= {r_q[13:0], div_ge};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd14) begin
                    if (r_part) r_hi <= h_div;
                    else        r_hr <= h_div;
                    r_part <= !r_part;
                end
            end
            ST_WIN_RD: begin
                if (!win_in) begin
                    // tap falls outside the carriers in use
                    r_fj <= last_j ? 5'd0 : (r_fj + 5'd1);
                    if (last_j) r_ti <= r_ti + 5'd1;
                end
            end
            ST_WIN_MUL: begin
                r_inc_re <= inc_now;
            end
            ST_WIN_WR: begin
                r_fj <= last_j ? 5'd0 : (r_fj + 5'd1);
                if (last_j) r_ti <= r_ti + 5'd1;
            end
            ST_DMUL: begin
                r_step <= r_step + 3'd1;
                unique case (r_step)
                    3'd2: r_acc_re <= 42'(r_prod);
                    3'd3: r_acc_re <= r_acc_re - 42'(r_prod);
                    3'd4: r_acc_im <= 42'(r_prod);
                    3'd5: r_acc_im <= r_acc_im + 42'(r_prod);
                    default: r_acc_re <= r_acc_re;
                endcase
            end
            ST_DOUT: begin
                if (out_free) begin
                    r_out.eq_re   <= y_re;
                    r_out.eq_im   <= y_im;
                    r_out.clipped <= clip_re || clip_im;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/pceq_checker.sv =====
// port-level checker for the equalizer, bound to the top level
`timescale 1ns / 1ps
`include "pilot_channel_interp_equalizer_unit_macros.svh"
module pceq_checker
    import pceq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_item   o_out_data,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [11:0] i_cfg_data
);

    // a stalled result transaction stays and holds its payload
    `PCEQ_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `PCEQ_ASSERT_NEXT(a_out_stable, i_clk, !i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // a data transaction keeps the input stalled while it is worked on
    `PCEQ_ASSERT_NEXT(a_busy_after_data, i_clk, !i_rst_n, i_in_valid && !o_in_stall && (i_in_data.operation == OP_DATA), o_in_stall)

    // the grid clearing pass follows reset
    `PCEQ_ASSERT_NEXT(a_clear_after_reset, i_clk, 1'b0, !i_rst_n, o_in_stall)

    // a new result only comes out of a busy period
    `PCEQ_ASSERT_SAME(a_result_from_busy, i_clk, !i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind pilot_channel_interp_equalizer_unit pceq_checker u_pceq_checker (.*);
